// ----- src/abps_pkg.sv -----
`default_nettype none
package abps_pkg;

  localparam int STORE_BYTES = 1048576;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  localparam int X_W      = 12;
  localparam int Y_W      = 12;
  localparam int COLOR_W  = 32;
  localparam int PIXEL_W  = 24;
  localparam int ROW_W    = 15;
  localparam int PIXB_W   = 3;
  localparam int CFG_W    = 15;
  localparam int ROWOFS_W = Y_W + ROW_W;
  localparam int PIXOFS_W = X_W + PIXB_W;
  localparam int SUM_W    = ROWOFS_W + 1;

  // last base address that still leaves room for three bytes
  localparam logic [SUM_W-1:0] LAST_BASE = SUM_W'(STORE_BYTES - 3);

  localparam logic [ROW_W-1:0]  ROW_BYTES_RST   = ROW_W'(1920);
  localparam logic [PIXB_W-1:0] PIXEL_BYTES_RST = PIXB_W'(3);

  typedef enum logic [0:0] {
    REG_ROW_BYTES   = 1'b0,
    REG_PIXEL_BYTES = 1'b1
  } cfg_reg_t;

  // color channel, also selects the byte within the pixel
  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_B    = 2'd1,
    CH_G    = 2'd2,
    CH_R    = 2'd3
  } chan_t;

  typedef struct packed {
    logic  clr_step;
    logic  load_item;
    logic  mul;
    logic  check;
    logic  mem_rd;
    logic  mem_wr;
    chan_t sel;
    chan_t cap;
    logic  load_result;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_err;
    logic is_read;
    logic out_free;
  } status_t;

  function automatic logic [1:0] chan_ofs(input chan_t ch);
    logic [1:0] ofs;
    unique case (ch)
      CH_B:    ofs = 2'd0;
      CH_G:    ofs = 2'd1;
      CH_R:    ofs = 2'd2;
      default: ofs = 2'd0;
    endcase
    return ofs;
  endfunction

endpackage
`default_nettype wire

// ----- src/abps_req_if.sv -----
`default_nettype none
interface abps_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [abps_pkg::X_W-1:0]      x;
  logic [abps_pkg::Y_W-1:0]      y;
  logic [abps_pkg::COLOR_W-1:0]  color;

  modport source (output valid, output req_type, output x, output y, output color,
                  input ready);
  modport sink   (input valid, input req_type, input x, input y, input color,
                  output ready);
endinterface
`default_nettype wire

// ----- src/abps_rsp_if.sv -----
`default_nettype none
interface abps_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [abps_pkg::PIXEL_W-1:0]  pixel;
  logic                          out_of_range;

  modport source (output valid, output pixel, output out_of_range, input ready);
  modport sink   (input valid, input pixel, input out_of_range, output ready);
endinterface
`default_nettype wire

// ----- src/abps_ctrl.sv -----
`default_nettype none
module abps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output abps_pkg::cmd_t         cmd,
  input  wire abps_pkg::status_t status
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_MUL    = 12'b0000_0000_0100,
    S_CHECK  = 12'b0000_0000_1000,
    S_RD_B   = 12'b0000_0001_0000,
    S_RD_G   = 12'b0000_0010_0000,
    S_RD_R   = 12'b0000_0100_0000,
    S_RD_END = 12'b0000_1000_0000,
    S_WR_B   = 12'b0001_0000_0000,
    S_WR_G   = 12'b0010_0000_0000,
    S_WR_R   = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    cmd.clr_step    = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.mul         = 1'b0;
    cmd.check       = 1'b0;
    cmd.mem_rd      = 1'b0;
    cmd.mem_wr      = 1'b0;
    cmd.sel         = abps_pkg::CH_NONE;
    cmd.cap         = abps_pkg::CH_NONE;
    cmd.load_result = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.range_err ? S_FINISH : S_RD_B;
      end
      // read data arrives in the cycle after its address
      S_RD_B: begin
        cmd.mem_rd = 1'b1;
        cmd.sel    = abps_pkg::CH_B;
        state_next = S_RD_G;
      end
      S_RD_G: begin
        cmd.mem_rd = 1'b1;
        cmd.sel    = abps_pkg::CH_G;
        cmd.cap    = abps_pkg::CH_B;
        state_next = S_RD_R;
      end
      S_RD_R: begin
        cmd.mem_rd = 1'b1;
        cmd.sel    = abps_pkg::CH_R;
        cmd.cap    = abps_pkg::CH_G;
        state_next = S_RD_END;
      end
      S_RD_END: begin
        cmd.cap    = abps_pkg::CH_R;
        state_next = status.is_read ? S_FINISH : S_WR_B;
      end
      S_WR_B: begin
        cmd.mem_wr = 1'b1;
        cmd.sel    = abps_pkg::CH_B;
        state_next = S_WR_G;
      end
      S_WR_G: begin
        cmd.mem_wr = 1'b1;
        cmd.sel    = abps_pkg::CH_G;
        state_next = S_WR_R;
      end
      S_WR_R: begin
        cmd.mem_wr = 1'b1;
        cmd.sel    = abps_pkg::CH_R;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/abps_dp.sv -----
`default_nettype none
module abps_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire abps_pkg::cmd_t                cmd,
  output abps_pkg::status_t                  status,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [abps_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_req_type,
  input  wire logic [abps_pkg::X_W-1:0]      in_x,
  input  wire logic [abps_pkg::Y_W-1:0]      in_y,
  input  wire logic [abps_pkg::COLOR_W-1:0]  in_color,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [abps_pkg::PIXEL_W-1:0]       out_pixel,
  output logic                               out_oor
);

  logic [abps_pkg::ROW_W-1:0]    row_bytes;
  logic [abps_pkg::PIXB_W-1:0]   pixel_bytes;
  logic                          is_read;
  logic [abps_pkg::X_W-1:0]      x;
  logic [abps_pkg::Y_W-1:0]      y;
  logic [abps_pkg::COLOR_W-1:0]  color;
  logic [abps_pkg::ROWOFS_W-1:0] row_ofs;
  logic [abps_pkg::PIXOFS_W-1:0] pix_ofs;
  logic [abps_pkg::SUM_W-1:0]    addr_sum;
  logic [abps_pkg::STORE_AW-1:0] base;
  logic                          oor;
  logic [abps_pkg::STORE_AW-1:0] clr_cnt;
  logic [7:0]                    old_b, old_g, old_r;
  logic [7:0]                    new_b, new_g, new_r;
  logic [7:0]                    mem [abps_pkg::STORE_BYTES];
  logic [7:0]                    rdata;
  logic [abps_pkg::STORE_AW-1:0] mem_addr;
  logic [7:0]                    wdata;
  logic                          mem_we;
  logic [7:0]                    alpha, fg, blend;
  logic [15:0]                   blend_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= abps_pkg::ROW_BYTES_RST;
      pixel_bytes <= abps_pkg::PIXEL_BYTES_RST;
    end else if (cfg_we) begin
      unique case (abps_pkg::cfg_reg_t'(cfg_index))
        abps_pkg::REG_ROW_BYTES:   row_bytes   <= cfg_data;
        abps_pkg::REG_PIXEL_BYTES: pixel_bytes <= cfg_data[abps_pkg::PIXB_W-1:0];
        default:                   row_bytes   <= row_bytes;
      endcase
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // item and address arithmetic
  assign addr_sum = abps_pkg::SUM_W'(row_ofs) + abps_pkg::SUM_W'(pix_ofs);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_read <= in_req_type;
      x       <= in_x;
      y       <= in_y;
      color   <= in_color;
    end
    if (cmd.mul) begin
      row_ofs <= abps_pkg::ROWOFS_W'(y) * abps_pkg::ROWOFS_W'(row_bytes);
      pix_ofs <= abps_pkg::PIXOFS_W'(x) * abps_pkg::PIXOFS_W'(pixel_bytes);
    end
    if (cmd.check) begin
      base <= addr_sum[abps_pkg::STORE_AW-1:0];
      oor  <= (addr_sum > abps_pkg::LAST_BASE);
    end
  end

  // byte memory, single port, registered read
  always_comb begin
    if (cmd.clr_step) begin
      mem_addr = clr_cnt;
      wdata    = 8'h00;
      mem_we   = 1'b1;
    end else begin
      mem_addr = base + abps_pkg::STORE_AW'(abps_pkg::chan_ofs(cmd.sel));
      mem_we   = cmd.mem_wr;
      unique case (cmd.sel)
        abps_pkg::CH_B: wdata = new_b;
        abps_pkg::CH_G: wdata = new_g;
        abps_pkg::CH_R: wdata = new_r;
        default:        wdata = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[mem_addr];
    end
  end

  // one channel blended per cycle as the old byte comes back
  assign alpha = color[31:24];

  always_comb begin
    unique case (cmd.cap)
      abps_pkg::CH_B: fg = color[23:16];
      abps_pkg::CH_G: fg = color[15:8];
      abps_pkg::CH_R: fg = color[7:0];
      default:        fg = 8'h00;
    endcase
  end

  assign blend_sum = ({8'h00, alpha} * {8'h00, fg})
                   + ({8'h00, 8'hFF - alpha} * {8'h00, rdata});
  assign blend     = blend_sum[15:8];

  always_ff @(posedge clk) begin
    unique case (cmd.cap)
      abps_pkg::CH_B: begin
        old_b <= rdata;
        new_b <= blend;
      end
      abps_pkg::CH_G: begin
        old_g <= rdata;
        new_g <= blend;
      end
      abps_pkg::CH_R: begin
        old_r <= rdata;
        new_r <= blend;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_oor <= oor;
      if (oor) begin
        out_pixel <= '0;
      end else if (is_read) begin
        out_pixel <= {old_b, old_g, old_r};
      end else begin
        out_pixel <= {new_b, new_g, new_r};
      end
    end
  end

  assign status.clr_last  = (clr_cnt == abps_pkg::STORE_AW'(abps_pkg::STORE_BYTES - 1));
  assign status.range_err = (addr_sum > abps_pkg::LAST_BASE);
  assign status.is_read   = is_read;
  assign status.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- src/alpha_blend_pixel_store_unit.sv -----
// channel | dir | transfer when        | payload
// req     | in  | req.valid & ready    | req_type, x, y, color
// rsp     | out | rsp.valid & ready    | pixel, out_of_range
// cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// one item at a time: a blended write steps MUL, CHECK, RD_B/G/R, RD_END, WR_B/G/R, FINISH;
// reads skip the writes, out-of-range items go from CHECK to FINISH; the single-port byte
// memory forces three reads, then three writes; after reset a clearing sweep zeroes the
// store, one byte a cycle, with req.ready low; cfg writes are taken during the sweep
// the result sits in an output register; a stalled rsp holds the next item in its last step
`default_nettype none
module alpha_blend_pixel_store_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  abps_req_if.sink                         req,
  abps_rsp_if.source                       rsp,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [abps_pkg::CFG_W-1:0]  cfg_data
);

  abps_pkg::cmd_t    cmd;
  abps_pkg::status_t status;
  logic              req_ready;

  assign req.ready = req_ready;

  abps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .status    (status)
  );

  abps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_req_type (req.req_type),
    .in_x        (req.x),
    .in_y        (req.y),
    .in_color    (req.color),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_pixel   (rsp.pixel),
    .out_oor     (rsp.out_of_range)
  );

endmodule
`default_nettype wire
